// ===== rtl/core/tgd_pkg.sv =====
// ----------------------------------------------------------------------------
// tgd_pkg
// shared types and constants of the tone generator with decay
// ----------------------------------------------------------------------------
package tgd_pkg;

   localparam int unsigned DivBits = 24;
   localparam int unsigned CntW    = $clog2(DivBits);

   localparam logic [2:0] RegWaveType      = 3'd0;
   localparam logic [2:0] RegPeriod        = 3'd1;
   localparam logic [2:0] RegInitialVolume = 3'd2;
   localparam logic [2:0] RegDiminish      = 3'd3;
   localparam logic [2:0] RegTickLength    = 3'd4;
   localparam logic [2:0] RegNoiseSeed     = 3'd5;

   localparam logic [1:0] WaveTriangle = 2'd0;
   localparam logic [1:0] WaveSaw      = 2'd1;
   localparam logic [1:0] WaveSquare   = 2'd2;
   localparam logic [1:0] WaveNoise    = 2'd3;

   localparam logic [1:0]  RstWaveType      = WaveTriangle;
   localparam logic [15:0] RstPeriod        = 16'd4096;
   localparam logic [7:0]  RstInitialVolume = 8'd64;
   localparam logic [6:0]  RstDiminish      = 7'd0;
   localparam logic [15:0] RstTickLength    = 16'd165;
   localparam logic [15:0] RstNoiseSeed     = 16'd1;

   localparam logic [15:0] LfsrMask = 16'hB400;
   localparam logic [7:0]  LevelMax = 8'd255;
   localparam logic signed [8:0] LevelMid = 9'sd128;

   typedef struct packed {
      logic [1:0]  wave_type;
      logic [15:0] period;
      logic [7:0]  initial_volume;
      logic [6:0]  diminish;
      logic [15:0] tick_length;
      logic [15:0] noise_seed;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic restart;
      logic setup;
      logic div_step;
      logic level;
      logic mul;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

// ===== rtl/core/tone_generator_with_decay.sv =====
// ----------------------------------------------------------------------------
// tone_generator_with_decay
// chiptune oscillator with four waveforms and stepwise volume decay
// ----------------------------------------------------------------------------
// Each request transaction yields one response sample. An item goes from
// acceptance through setup, the 24-step serial restoring divider that forms
// the triangle and saw levels, level select and multiply to commit, which
// waits while the output register holds an unaccepted sample. One item is
// in work at a time, and a new request is taken while the previous sample
// still waits in the output register. Settings written during an item can
// change it; volume and noise seed load only when an item carries restart.
module tone_generator_with_decay
   import tgd_pkg::*;
#(
   parameter int unsigned PHASE_STEP = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // restart, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // sample (signed), zero fill
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   cmd_type           cmd;
   sts_type           sts;
   logic signed [6:0] sample;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            RegWaveType:      cfg_in.wave_type      = csr_wdata[1:0];
            RegPeriod:        cfg_in.period         = csr_wdata;
            RegInitialVolume: cfg_in.initial_volume = csr_wdata[7:0];
            RegDiminish:      cfg_in.diminish       = csr_wdata[6:0];
            RegTickLength:    cfg_in.tick_length    = csr_wdata;
            RegNoiseSeed:     cfg_in.noise_seed     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_type      <= RstWaveType;
         cfg_ff.period         <= RstPeriod;
         cfg_ff.initial_volume <= RstInitialVolume;
         cfg_ff.diminish       <= RstDiminish;
         cfg_ff.tick_length    <= RstTickLength;
         cfg_ff.noise_seed     <= RstNoiseSeed;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tgd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .sts         (sts)
   );

   tgd_datapath #(
      .PHASE_STEP (PHASE_STEP)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (cmd),
      .sts    (sts),
      .sample (sample)
   );

   assign rsp_tdata = {1'b0, sample};

   // no pending sample is overwritten
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("sample committed over a pending response");

   // a committed sample is offered next cycle
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed sample not presented");

   // one item in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request accepted while busy");

   // divider runs only after setup or a previous step
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> ($past(cmd.setup) || $past(cmd.div_step)))
      else $error("divider step without setup");

endmodule

// ===== rtl/core/tgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgd_ctrl
// sequencer for one sample: setup, serial divide, level, multiply, commit
// ----------------------------------------------------------------------------
module tgd_ctrl
   import tgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    req_restart,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_LEVEL = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start   = 1'b1;
               cmd.restart = req_restart;
               state_in    = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/tgd_datapath.sv =====
// ----------------------------------------------------------------------------
// tgd_datapath
// oscillator state, serial divider, level select, volume multiply and scaling
// ----------------------------------------------------------------------------
module tgd_datapath
   import tgd_pkg::*;
#(
   parameter int unsigned PHASE_STEP = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic signed [6:0] sample
);

   logic [15:0]        phase_ff, phase_in;
   logic [15:0]        vol_ff, vol_in;
   logic [15:0]        tick_ff, tick_in;
   logic [15:0]        lfsr_ff, lfsr_in;
   logic [15:0]        divisor_ff, divisor_in;
   logic [15:0]        rem_ff, rem_in;
   logic [DivBits-1:0] quo_ff, quo_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic signed [8:0]  lvc_ff, lvc_in;
   logic signed [15:0] prod_ff, prod_in;
   logic signed [6:0]  sample_ff, sample_in;

   logic [15:0]        per, half, num, tl;
   logic               below_half, fits;
   logic [DivBits-1:0] dividend;
   logic [16:0]        shifted, diff;
   logic               q_big;
   logic [7:0]         q_sat, q_inv, lv;
   logic signed [17:0] prod_full;
   logic signed [15:0] adj, scaled;
   logic [16:0]        drop, tick_inc, sum, sum1;
   logic [15:0]        vol_dec, phase_next, lfsr_next;

   assign per        = (cfg.period[15:1] == 15'd0) ? 16'd2 : cfg.period;
   assign half       = {1'b0, per[15:1]};
   assign below_half = (phase_ff < half);
   assign num        = (cfg.wave_type == WaveTriangle && !below_half) ? phase_ff - half
                                                                       : phase_ff;
   // 255 * num
   assign dividend   = {num, 8'd0} - {8'd0, num};

   assign shifted = {rem_ff, quo_ff[DivBits-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   assign q_big = |quo_ff[DivBits-1:8];
   assign q_sat = q_big ? LevelMax : quo_ff[7:0];
   assign q_inv = q_big ? 8'd0 : LevelMax - quo_ff[7:0];

   always_comb begin
      case (cfg.wave_type)
         WaveTriangle: lv = below_half ? q_sat : q_inv;
         WaveSaw:      lv = q_inv;
         WaveSquare:   lv = below_half ? 8'd0 : LevelMax;
         default:      lv = lfsr_ff[7:0];
      endcase
   end

   assign prod_full = lvc_ff * $signed({1'b0, vol_ff[15:8]});

   // divide by 64 toward zero, then floor shift by 3
   assign adj    = prod_ff + (prod_ff[15] ? 16'sd63 : 16'sd0);
   assign scaled = (adj >>> 6) >>> 3;

   assign drop    = 17'(vol_ff[15:6] * cfg.diminish);
   assign vol_dec = (drop >= {1'b0, vol_ff}) ? 16'd0 : vol_ff - drop[15:0];

   assign tl       = (cfg.tick_length == 16'd0) ? 16'd1 : cfg.tick_length;
   assign tick_inc = {1'b0, tick_ff} + 17'd1;

   assign sum        = {1'b0, phase_ff} + 17'(PHASE_STEP);
   assign sum1       = (sum >= {1'b0, per}) ? sum - {1'b0, per} : sum;
   assign phase_next = (sum1 >= {1'b0, per}) ? 16'd0 : sum1[15:0];

   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LfsrMask) : (lfsr_ff >> 1);

   always_comb begin
      phase_in   = phase_ff;
      vol_in     = vol_ff;
      tick_in    = tick_ff;
      lfsr_in    = lfsr_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      lvc_in     = lvc_ff;
      prod_in    = prod_ff;
      sample_in  = sample_ff;
      if (cmd.start && cmd.restart) begin
         phase_in = 16'd0;
         vol_in   = {cfg.initial_volume, 8'd0};
         tick_in  = 16'd0;
         lfsr_in  = (cfg.noise_seed == 16'd0) ? 16'd1 : cfg.noise_seed;
      end
      if (cmd.setup) begin
         divisor_in = (cfg.wave_type == WaveTriangle) ? half : per;
         rem_in     = 16'd0;
         quo_in     = dividend;
         cnt_in     = CntW'(DivBits - 1);
      end
      if (cmd.div_step) begin
         rem_in = fits ? diff[15:0] : shifted[15:0];
         quo_in = {quo_ff[DivBits-2:0], fits};
         cnt_in = cnt_ff - CntW'(1);
      end
      if (cmd.level) begin
         lvc_in = $signed({1'b0, lv}) - LevelMid;
      end
      if (cmd.mul) begin
         prod_in = prod_full[15:0];
      end
      if (cmd.commit) begin
         sample_in = scaled[6:0];
         if (tick_ff == 16'd0) begin
            vol_in = vol_dec;
         end
         tick_in  = (tick_inc >= {1'b0, tl}) ? 16'd0 : tick_inc[15:0];
         phase_in = phase_next;
         lfsr_in  = lfsr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 16'd0;
         vol_ff   <= {RstInitialVolume, 8'd0};
         tick_ff  <= 16'd0;
         lfsr_ff  <= RstNoiseSeed;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         vol_ff   <= vol_in;
         tick_ff  <= tick_in;
         lfsr_ff  <= lfsr_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      lvc_ff     <= lvc_in;
      prod_ff    <= prod_in;
      sample_ff  <= sample_in;
   end

   assign sts.div_last = (cnt_ff == '0);
   assign sample       = sample_ff;

endmodule
